// ----- hw/rtl/b64d_pkg.sv -----
// Shared types, constants and character lookup functions for the base64 stream decoder.
// Used by every module under hw/rtl; depends on nothing.
`timescale 1ns / 1ps

package b64d_pkg;

   localparam int COUNT_BITS = 16;
   localparam int LIMIT_BITS = 16;
   localparam int OUT_COUNT_BITS = 16;
   localparam int CMP_BITS = (COUNT_BITS >= LIMIT_BITS) ? COUNT_BITS + 1 : LIMIT_BITS + 1;
   localparam int QDEPTH = 4;
   localparam int QPTR_BITS = $clog2(QDEPTH);

   localparam logic [7:0] PAD_CHAR = 8'h3D;
   localparam logic [7:0] NUL_CHAR = 8'h00;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = '1;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_END  = 2'd1,
      KIND_OVF  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      TAIL_NONE = 2'd0,
      TAIL_END  = 2'd1,
      TAIL_OVF  = 2'd2
   } tail_type;

   // One decoded group or stream event, expanded by the back end into words.
   typedef struct packed {
      logic [1:0]                n_bytes;
      logic [2:0][7:0]           bytes;
      tail_type                  tail;
      logic [OUT_COUNT_BITS-1:0] count;
   } cmd_type;

   function automatic logic [5:0] sextet_of(input logic [7:0] c);
      logic [5:0] s;
      s = 6'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         s = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         s = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         s = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         s = 6'd62;
      end else if (c == 8'h2F) begin
         s = 6'd63;
      end
      return s;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

endpackage

// ----- hw/rtl/base64_stream_decoder.sv -----
// Base64 stream decoder: one character per cycle in, decoded bytes and stream events out.
// A result passes a queue slot, the back end's command register and the output register.
// Throughput: one character per cycle unless full and one result word per cycle while
// popped; each group expands into up to three words; a four-entry queue absorbs stalls.
// Reset (synchronous, active high) re-arms the decoder, empties the queue and output
// register, and sets the decoded-byte limit to 65535.
`timescale 1ns / 1ps

module base64_stream_decoder
   import b64d_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic [7:0]                req_ch,
   output logic                      empty,
   input  logic                      pop,
   output logic [1:0]                rsp_kind,
   output logic [7:0]                rsp_data_byte,
   output logic [OUT_COUNT_BITS-1:0] rsp_byte_count,
   output logic                      rsp_last,
   input  logic                      csr_wr_en,
   input  logic [LIMIT_BITS-1:0]     csr_wr_data
);

   logic    accept;
   logic    cmd_push;
   cmd_type cmd;
   cmd_type q_cmd;
   logic    q_pop;
   logic    q_empty;
   logic    q_full;

   assign full   = q_full;
   assign accept = push && !q_full;

   b64d_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .ch          (req_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd_push    (cmd_push),
      .cmd         (cmd)
   );

   b64d_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_push),
      .wr_cmd  (cmd),
      .rd_en   (q_pop),
      .rd_cmd  (q_cmd),
      .q_full  (q_full),
      .q_empty (q_empty)
   );

   b64d_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_cmd          (q_cmd),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .pop            (pop),
      .empty          (empty),
      .rsp_kind       (rsp_kind),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_byte_count (rsp_byte_count),
      .rsp_last       (rsp_last)
   );

endmodule

// ----- hw/rtl/b64d_front.sv -----
// Front end: takes characters, tracks group position and count, builds group commands.
// Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_front
   import b64d_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            ch,
   input  logic                  csr_wr_en,
   input  logic [LIMIT_BITS-1:0] csr_wr_data,
   output logic                  cmd_push,
   output cmd_type               cmd
);

   logic [1:0]            pos_ff, pos_in;
   logic [5:0]            sext_ff [3];
   logic [5:0]            sext_in [3];
   logic                  third_pad_ff, third_pad_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  finished_ff, finished_in;
   logic [LIMIT_BITS-1:0] limit_ff, limit_in;

   logic [5:0]            s;
   logic [CMP_BITS-1:0]   count_ext;
   logic [CMP_BITS-1:0]   limit_ext;
   logic                  overflow;
   logic [1:0]            n;
   logic [COUNT_BITS-1:0] count_next;
   logic [CMP_BITS-1:0]   count_next_ext;

   always_comb begin
      s              = sextet_of(ch);
      count_ext      = {{(CMP_BITS-COUNT_BITS){1'b0}}, count_ff};
      limit_ext      = {{(CMP_BITS-LIMIT_BITS){1'b0}}, limit_ff};
      overflow       = (count_ext + CMP_BITS'(4)) >= limit_ext;
      if (third_pad_ff) begin
         n = 2'd1;
      end else if (ch == PAD_CHAR) begin
         n = 2'd2;
      end else begin
         n = 2'd3;
      end
      count_next     = count_ff + COUNT_BITS'(n);
      count_next_ext = {{(CMP_BITS-COUNT_BITS){1'b0}}, count_next};
   end

   always_comb begin
      pos_in       = pos_ff;
      sext_in      = sext_ff;
      third_pad_in = third_pad_ff;
      count_in     = count_ff;
      finished_in  = finished_ff;
      limit_in     = csr_wr_en ? csr_wr_data : limit_ff;
      cmd_push     = 1'b0;
      cmd.n_bytes  = 2'd0;
      cmd.bytes[0] = {sext_ff[0], sext_ff[1][5:4]};
      cmd.bytes[1] = {sext_ff[1][3:0], sext_ff[2][5:2]};
      cmd.bytes[2] = {sext_ff[2][1:0], s};
      cmd.tail     = TAIL_END;
      cmd.count    = count_ext[OUT_COUNT_BITS-1:0];

      if (accept) begin
         priority if (ch == NUL_CHAR) begin
            // report the count unless an end or overflow already did, then re-arm
            cmd_push     = !finished_ff;
            pos_in       = 2'd0;
            sext_in      = '{default: 6'd0};
            third_pad_in = 1'b0;
            count_in     = '0;
            finished_in  = 1'b0;
         end else if (finished_ff || is_blank(ch)) begin
            // drop
         end else if (pos_ff != 2'd3) begin
            sext_in[pos_ff] = s;
            if (pos_ff == 2'd2) begin
               third_pad_in = (ch == PAD_CHAR);
            end
            pos_in = pos_ff + 2'd1;
         end else begin
            pos_in   = 2'd0;
            cmd_push = 1'b1;
            if (overflow) begin
               finished_in = 1'b1;
               cmd.tail    = TAIL_OVF;
            end else begin
               cmd.n_bytes  = n;
               cmd.count    = count_next_ext[OUT_COUNT_BITS-1:0];
               count_in     = count_next;
               third_pad_in = 1'b0;
               if (n == 2'd3) begin
                  cmd.tail = TAIL_NONE;
               end else begin
                  finished_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 2'd0;
         sext_ff      <= '{default: 6'd0};
         third_pad_ff <= 1'b0;
         count_ff     <= '0;
         finished_ff  <= 1'b0;
         limit_ff     <= LIMIT_RESET;
      end else begin
         pos_ff       <= pos_in;
         sext_ff      <= sext_in;
         third_pad_ff <= third_pad_in;
         count_ff     <= count_in;
         finished_ff  <= finished_in;
         limit_ff     <= limit_in;
      end
   end

endmodule

// ----- hw/rtl/b64d_queue.sv -----
// Short command queue between the front and back ends, held in flip-flops.
// Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_queue
   import b64d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  cmd_type wr_cmd,
   input  logic    rd_en,
   output cmd_type rd_cmd,
   output logic    q_full,
   output logic    q_empty
);

   cmd_type              slot_ff [QDEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   fill_ff, fill_in;

   always_comb begin
      q_full    = (fill_ff == (QPTR_BITS+1)'(QDEPTH));
      q_empty   = (fill_ff == '0);
      rd_cmd    = slot_ff[rd_ptr_ff];
      wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (QPTR_BITS+1)'(wr_en) - (QPTR_BITS+1)'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ----- hw/rtl/b64d_back.sv -----
// Back end: expands queued commands into words in an output register, one per cycle while popped.
// Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_back
   import b64d_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   q_cmd,
   input  logic                      q_empty,
   output logic                      q_pop,
   input  logic                      pop,
   output logic                      empty,
   output logic [1:0]                rsp_kind,
   output logic [7:0]                rsp_data_byte,
   output logic [OUT_COUNT_BITS-1:0] rsp_byte_count,
   output logic                      rsp_last
);

   cmd_type                   cmd_ff, cmd_in;
   logic                      cmd_vld_ff, cmd_vld_in;
   logic [1:0]                step_ff, step_in;
   logic                      out_vld_ff, out_vld_in;
   kind_type                  kind_ff, kind_in;
   logic [7:0]                byte_ff, byte_in;
   logic [OUT_COUNT_BITS-1:0] count_ff, count_in;
   logic                      last_ff, last_in;

   logic       out_free;
   logic       advance;
   logic       final_step;
   logic [2:0] total;
   logic       load;

   always_comb begin
      out_free   = !out_vld_ff || pop;
      advance    = cmd_vld_ff && out_free;
      total      = {1'b0, cmd_ff.n_bytes} + {2'b00, cmd_ff.tail != TAIL_NONE};
      final_step = ({1'b0, step_ff} + 3'd1) == total;
      load       = !cmd_vld_ff || (advance && final_step);
      q_pop      = load && !q_empty;

      cmd_in     = q_pop ? q_cmd : cmd_ff;
      cmd_vld_in = q_pop ? 1'b1 : (load ? 1'b0 : cmd_vld_ff);
      if (load) begin
         step_in = 2'd0;
      end else if (advance) begin
         step_in = step_ff + 2'd1;
      end else begin
         step_in = step_ff;
      end

      // word selected by the current step: data bytes first, then the tail
      if (step_ff < cmd_ff.n_bytes) begin
         kind_in  = KIND_DATA;
         byte_in  = cmd_ff.bytes[step_ff];
         count_in = '0;
         last_in  = (cmd_ff.n_bytes == 2'd3) && (step_ff == 2'd2);
      end else begin
         kind_in  = (cmd_ff.tail == TAIL_OVF) ? KIND_OVF : KIND_END;
         byte_in  = 8'd0;
         count_in = cmd_ff.count;
         last_in  = 1'b1;
      end

      if (advance) begin
         out_vld_in = 1'b1;
      end else if (pop) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end

      empty          = !out_vld_ff;
      rsp_kind       = kind_ff;
      rsp_data_byte  = byte_ff;
      rsp_byte_count = count_ff;
      rsp_last       = last_ff;
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (advance) begin
         kind_ff  <= kind_in;
         byte_ff  <= byte_in;
         count_ff <= count_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_vld_ff <= 1'b0;
         step_ff    <= 2'd0;
         out_vld_ff <= 1'b0;
      end else begin
         cmd_vld_ff <= cmd_vld_in;
         step_ff    <= step_in;
         out_vld_ff <= out_vld_in;
      end
   end

endmodule
